/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset disable; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/mh64_pkg.sv */
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants and types of the 64-bit stream hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package mh64_pkg;

  localparam logic [63:0] HASH_MUL    = 64'hc6a4a7935bd1e995;
  localparam int unsigned HASH_SHIFT  = 47;
  localparam int unsigned QUEUE_DEPTH = 4;

  // What the back end does with an item's word
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_FULL = 2'd2
  } word_kind_t;

  // Classified item, as queued between front and back
  typedef struct packed {
    word_kind_t  kind;
    logic        start;
    logic        last;
    logic [63:0] word;
    logic [30:0] len;
  } item_t;

  function automatic logic [63:0] xor_shift(input logic [63:0] v);
    return v ^ (v >> HASH_SHIFT);
  endfunction

endpackage

`default_nettype wire

/* rtl/mh64_front.sv */
// ----------------------------------------------------------------------------
// mh64_front
// Accepts input items, tracks message framing, masks tails and classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_front
  import mh64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [63:0] in_data_word,
  input  wire logic [3:0]  in_valid_bytes,
  input  wire logic        in_first_word,
  input  wire logic        in_last_word,
  input  wire logic [30:0] in_message_length,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  logic        in_message_r, in_message_nxt;
  logic        accept;
  logic        keep;
  logic [63:0] mask;

  assign in_full = q_full_i;
  assign accept  = in_push && !q_full_i;
  // drop items that arrive outside a message
  assign keep     = in_first_word || in_message_r;
  assign q_push_o = accept && keep;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = (in_valid_bytes > 4'(b)) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    q_item_o.start = in_first_word;
    q_item_o.last  = in_last_word;
    q_item_o.len   = in_message_length;
    q_item_o.word  = in_data_word & mask;
    if (in_valid_bytes == 4'd0) begin
      q_item_o.kind = KIND_NONE;
    end else if (in_valid_bytes >= 4'd8) begin
      q_item_o.kind = KIND_FULL;
    end else begin
      q_item_o.kind = KIND_TAIL;
    end
  end

  always_comb begin
    in_message_nxt = in_message_r;
    if (q_push_o) begin
      in_message_nxt = !in_last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_message_r <= 1'b0;
    end else begin
      in_message_r <= in_message_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/mh64_queue.sv */
// ----------------------------------------------------------------------------
// mh64_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mh64_queue
  import mh64_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= item_i;
    end
  end

  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop_i && empty_o, "queue popped while empty")
  `ASSERT_NEVER(a_count_range, clk, rst_n, count_r > CNT_W'(DEPTH), "queue count past depth")
  `ASSERT_PROP(a_count_up, clk, rst_n, (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1), "queue count did not advance")

endmodule

`default_nettype wire

/* rtl/mh64_mul.sv */
// ----------------------------------------------------------------------------
// mh64_mul
// Two-stage multiply by the hash constant, low 64 bits of the product.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_mul
  import mh64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go_i,
  input  wire logic [63:0] a_i,
  output logic             done_o,
  output logic [63:0]      res_o
);

  localparam logic [31:0] MUL_LO = HASH_MUL[31:0];
  localparam logic [31:0] MUL_HI = HASH_MUL[63:32];

  logic        v1_r, v2_r;
  logic [63:0] pp_ll_r;
  logic [31:0] pp_hl_r, pp_lh_r;
  logic [63:0] res_r;
  logic [31:0] cross_sum;

  // stage one: partial products, only the low half of the cross terms matters
  always_ff @(posedge clk) begin
    pp_ll_r <= 64'(a_i[31:0]) * 64'(MUL_LO);
    pp_hl_r <= a_i[63:32] * MUL_LO;
    pp_lh_r <= a_i[31:0] * MUL_HI;
  end

  assign cross_sum = pp_hl_r + pp_lh_r;

  always_ff @(posedge clk) begin
    res_r <= pp_ll_r + {cross_sum, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= go_i;
      v2_r <= v1_r;
    end
  end

  assign done_o = v2_r;
  assign res_o  = res_r;

endmodule

`default_nettype wire

/* rtl/mh64_back.sv */
// ----------------------------------------------------------------------------
// mh64_back
// Sequences the hash steps of each queued item over the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mh64_back
  import mh64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_data,
  input  wire logic        q_empty_i,
  input  item_t            q_head_i,
  output logic             q_pop_o,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [63:0]      out_hash_value
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_WAIT,
    ST_DISPATCH,
    ST_W1_WAIT,
    ST_W3_WAIT,
    ST_H_WAIT,
    ST_FIN_WAIT,
    ST_OUT
  } state_t;

  state_t      state_r, state_nxt;
  item_t       it_r, it_nxt;
  logic [63:0] seed_r;
  logic [63:0] h_r, h_nxt;
  logic [63:0] fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic        mul_go;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_res;

  mh64_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign out_empty      = !out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    state_nxt     = state_r;
    it_nxt        = it_r;
    h_nxt         = h_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_hash_nxt  = out_hash_r;
    q_pop_o       = 1'b0;
    mul_go        = 1'b0;
    mul_a         = h_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          it_nxt  = q_head_i;
          if (q_head_i.start) begin
            mul_go    = 1'b1;
            mul_a     = {33'd0, q_head_i.len};
            state_nxt = ST_LEN_WAIT;
          end else begin
            state_nxt = ST_DISPATCH;
          end
        end
      end
      ST_LEN_WAIT: begin
        if (mul_done) begin
          h_nxt     = seed_r ^ mul_res;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (it_r.kind)
          KIND_FULL: begin
            mul_go    = 1'b1;
            mul_a     = it_r.word;
            state_nxt = ST_W1_WAIT;
          end
          KIND_TAIL: begin
            mul_go    = 1'b1;
            mul_a     = h_r ^ it_r.word;
            state_nxt = ST_H_WAIT;
          end
          default: begin
            if (it_r.last) begin
              mul_go    = 1'b1;
              mul_a     = xor_shift(h_r);
              state_nxt = ST_FIN_WAIT;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_W1_WAIT: begin
        if (mul_done) begin
          mul_go    = 1'b1;
          mul_a     = xor_shift(mul_res);
          state_nxt = ST_W3_WAIT;
        end
      end
      ST_W3_WAIT: begin
        if (mul_done) begin
          mul_go    = 1'b1;
          mul_a     = h_r ^ mul_res;
          state_nxt = ST_H_WAIT;
        end
      end
      ST_H_WAIT: begin
        if (mul_done) begin
          h_nxt = mul_res;
          if (it_r.last) begin
            mul_go    = 1'b1;
            mul_a     = xor_shift(mul_res);
            state_nxt = ST_FIN_WAIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN_WAIT: begin
        if (mul_done) begin
          fin_nxt   = xor_shift(mul_res);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold the finished hash until the output register frees up
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = fin_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= 64'd0;
      h_r         <= 64'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
      if (cfg_we) begin
        seed_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    it_r       <= it_nxt;
    fin_r      <= fin_nxt;
    out_hash_r <= out_hash_nxt;
  end

  `ASSERT_PROP(a_done_in_wait, clk, rst_n, mul_done |-> (state_r == ST_LEN_WAIT || state_r == ST_W1_WAIT || state_r == ST_W3_WAIT || state_r == ST_H_WAIT || state_r == ST_FIN_WAIT), "multiplier result outside a wait state")
  `ASSERT_PROP(a_no_back_to_back_go, clk, rst_n, mul_go |=> !mul_go, "multiplier issued while busy")
  `ASSERT_PROP(a_result_held, clk, rst_n, (out_valid_r && !out_pop) |=> (out_valid_r && $stable(out_hash_r)), "pending hash lost")

endmodule

`default_nettype wire

/* rtl/murmur_hash_64bit_stream_unit.sv */
// ----------------------------------------------------------------------------
// murmur_hash_64bit_stream_unit
// Streaming 64-bit multiply/xor-shift message hash with a seed register.
//
// Channel   Direction  Handshake         Payload
// in_       input      in_push/in_full   data_word, valid_bytes, first/last, length
// out_      output     out_pop/out_empty hash_value
// cfg_      input      cfg_we            cfg_data (seed)
//
// Each queued item is worked in the back end on the shared two-stage
// multiply-by-constant unit, used up to five times per item
// (length mix, two word multiplies, hash multiply, final mix).
// Items outside a message are dropped at the front.
// The front keeps accepting until the item queue is full; a waiting result
// stalls the back end only at its final hand-off. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur_hash_64bit_stream_unit
  import mh64_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [63:0] in_data_word,
  input  wire logic [3:0]  in_valid_bytes,
  input  wire logic        in_first_word,
  input  wire logic        in_last_word,
  input  wire logic [30:0] in_message_length,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [63:0]      out_hash_value,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_data
);

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_item, q_head;

  mh64_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_word      (in_data_word),
    .in_valid_bytes    (in_valid_bytes),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_item_o          (q_item)
  );

  mh64_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .item_i  (q_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  mh64_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value)
  );

endmodule

`default_nettype wire

/* dv/murmur_hash_64bit_stream_unit_tb.sv */
// ----------------------------------------------------------------------------
// murmur_hash_64bit_stream_unit_tb
// Checks the streaming 64-bit message hash against a model of its own. The
// model tracks the seed and the running hash. A table of directed items runs
// first, then random messages under several seeds. Random stalls fall on both
// sides, with one long receiver hold-off. Every hash that comes out is checked
// against the oldest pending expected value.
// ----------------------------------------------------------------------------
module murmur_hash_64bit_stream_unit_tb;
  import mh64_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS = 175;
  localparam int DIR_ROWS = 22;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        first;
    logic        last;
    logic [30:0] len;
    logic        pinned;  // hash below is typed in, not predicted
    logic [63:0] hash;
  } hash_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_valid_bytes = '0;
  logic        in_first_word = 1'b0;
  logic        in_last_word = 1'b0;
  logic [30:0] in_message_length = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [63:0] out_hash_value;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_data = '0;

  // Model state
  logic [63:0] seed_copy = '0;
  logic [63:0] acc_hash = '0;
  bit          msg_open = 1'b0;
  logic [63:0] hash_expect [$];
  int          err_count = 0;
  int          hashes_seen = 0;
  int          absorbed = 0;
  bit          calm = 1'b0;

  hash_item_t  dir_rows [DIR_ROWS];

  always #5 clk = ~clk;

  murmur_hash_64bit_stream_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_word      (in_data_word),
    .in_valid_bytes    (in_valid_bytes),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_hash_value    (out_hash_value),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data)
  );

  function automatic logic [63:0] scramble(input logic [63:0] w);
    w = w * HASH_MUL;
    w = w ^ (w >> HASH_SHIFT);
    w = w * HASH_MUL;
    return w;
  endfunction

  // Fold one item into the running hash; return 1 when a hash comes out
  function automatic bit absorb_item(input hash_item_t it, output logic [63:0] digest);
    logic [3:0]  nb;
    logic [63:0] mask;
    digest = '0;
    if (it.first) begin
      acc_hash = seed_copy ^ ({33'd0, it.len} * HASH_MUL);
      msg_open = 1'b1;
    end else if (!msg_open) begin
      return 1'b0;
    end
    absorbed++;
    nb = (it.nbytes > 4'd8) ? 4'd8 : it.nbytes;
    if (nb == 4'd8) begin
      acc_hash = (acc_hash ^ scramble(it.word)) * HASH_MUL;
    end else if (nb != 4'd0) begin
      mask = (64'd1 << (8 * nb)) - 64'd1;
      acc_hash = (acc_hash ^ (it.word & mask)) * HASH_MUL;
    end
    if (it.last) begin
      digest = acc_hash ^ (acc_hash >> HASH_SHIFT);
      digest = digest * HASH_MUL;
      digest = digest ^ (digest >> HASH_SHIFT);
      msg_open = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    err_count++;
  endtask

  task automatic send_item(input hash_item_t it);
    int          gap;
    logic [63:0] digest;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_data_word      <= it.word;
    in_valid_bytes    <= it.nbytes;
    in_first_word     <= it.first;
    in_last_word      <= it.last;
    in_message_length <= it.len;
    do @(posedge clk); while (in_full);
    if (absorb_item(it, digest)) hash_expect.push_back(it.pinned ? it.hash : digest);
  endtask

  // Hold the input until every hash is out and the back end has gone quiet
  task automatic drain_and_settle();
    in_push <= 1'b0;
    while (hash_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] value);
    drain_and_settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_copy = value;
  endtask

  task automatic send_random_message();
    hash_item_t it;
    hash_item_t pad;
    int         total;
    int         left;
    int         take;
    int         r;
    bit         drop_last;
    it = '0;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // stray item without a start
      it.word   = rand_word();
      it.nbytes = 4'($urandom_range(0, 15));
      it.last   = 1'($urandom_range(0, 1));
      it.len    = 31'($urandom);
      send_item(it);
      return;
    end
    r = $urandom_range(0, 99);
    total = (r < 80) ? $urandom_range(0, 40) :
            (r < 97) ? $urandom_range(41, 120) : $urandom_range(121, 400);
    drop_last = ($urandom_range(0, 99) < 5);
    left = total;
    it.first = 1'b1;
    it.len = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'(total);
    do begin
      take = (left >= 8) ? 8 : left;
      left -= take;
      it.word   = rand_word();
      it.nbytes = 4'(take);
      it.last   = (left == 0);
      r = $urandom_range(0, 39);
      if (r == 0 && take == 8) it.nbytes = 4'($urandom_range(9, 15));
      if (r == 1 && !it.last) it.nbytes = 4'($urandom_range(1, 7));
      // leave the message open; the next start drops it
      if (it.last && drop_last) break;
      send_item(it);
      it.first = 1'b0;
      if (!it.last && $urandom_range(0, 29) == 0) begin
        pad = it;
        pad.word   = rand_word();
        pad.nbytes = 4'd0;
        send_item(pad);
      end
    end while (left > 0);
  endtask

  initial begin
    logic [63:0] seeds [4];
    int          base;
    dir_rows = '{
      '{64'h0,                   4'd0,  1'b1, 1'b1, 31'd0,          1'b1, 64'h0},
      '{64'hdead_beef_0123_4567, 4'd8,  1'b0, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 4'd8,  1'b1, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'h0,                   4'd8,  1'b1, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 4'd1,  1'b1, 1'b1, 31'd1,          1'b0, 64'h0},
      '{64'h0102_0304_0506_0708, 4'd7,  1'b1, 1'b1, 31'd7,          1'b0, 64'h0},
      '{64'h8877_6655_4433_2211, 4'd15, 1'b1, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'h8877_6655_4433_2211, 4'd9,  1'b1, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'h8877_6655_4433_2211, 4'd8,  1'b1, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'h0706_0504_0302_0100, 4'd8,  1'b1, 1'b0, 31'd20,         1'b0, 64'h0},
      '{64'h0f0e_0d0c_0b0a_0908, 4'd8,  1'b0, 1'b0, 31'd20,         1'b0, 64'h0},
      '{64'hffff_ffff_1312_1110, 4'd4,  1'b0, 1'b1, 31'd20,         1'b0, 64'h0},
      '{64'haaaa_aaaa_aaaa_aaaa, 4'd3,  1'b1, 1'b0, 31'd11,         1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 4'd8,  1'b0, 1'b1, 31'd11,         1'b0, 64'h0},
      '{64'h1111_1111_1111_1111, 4'd8,  1'b1, 1'b0, 31'd16,         1'b0, 64'h0},
      '{64'h2222_2222_2222_2222, 4'd8,  1'b1, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'h3333_3333_3333_3333, 4'd8,  1'b1, 1'b0, 31'd8,          1'b0, 64'h0},
      '{64'h4444_4444_4444_4444, 4'd0,  1'b0, 1'b1, 31'd8,          1'b0, 64'h0},
      '{64'h0,                   4'd0,  1'b1, 1'b1, 31'h7fff_ffff,  1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 4'd8,  1'b1, 1'b1, 31'd0,          1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 4'd0,  1'b0, 1'b0, 31'd0,          1'b0, 64'h0},
      '{64'hfedc_ba98_7654_3210, 4'd7,  1'b1, 1'b1, 31'h7fff_ffff,  1'b0, 64'h0}
    };
    seeds[0] = '1;
    seeds[1] = {$urandom, $urandom};
    seeds[2] = {$urandom, $urandom};
    seeds[3] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    for (int k = 0; k < 4; k++) begin
      load_seed(seeds[k]);
      calm = (k == 2);
      base = absorbed;
      while (absorbed < base + PHASE_ITEMS) send_random_message();
      calm = 1'b0;
    end
    drain_and_settle();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: check each popped hash, stall at random, one long hold-off
  initial begin
    int          hold_left;
    bit          big_hold_done;
    logic [63:0] want;
    hold_left = 0;
    big_hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        hashes_seen++;
        if (hash_expect.size() == 0) begin
          report_mismatch("hash with none pending", 'x, out_hash_value);
        end else begin
          want = hash_expect.pop_front();
          if (out_hash_value !== want) report_mismatch("hash_value", want, out_hash_value);
        end
      end
      if (hold_left == 0) begin
        if (!big_hold_done && hashes_seen >= 60) begin
          big_hold_done = 1'b1;
          hold_left = 400;
        end else begin
          hold_left = pick_gap();
        end
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* murmur_hash_64bit_stream_unit.f */
+incdir+rtl
rtl/mh64_pkg.sv
rtl/mh64_front.sv
rtl/mh64_queue.sv
rtl/mh64_mul.sv
rtl/mh64_back.sv
rtl/murmur_hash_64bit_stream_unit.sv
dv/murmur_hash_64bit_stream_unit_tb.sv
